// File: src/ctc_pkg.sv
// Shared types and constants of the capability table check unit.
package ctc_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DEC_DENY     = 2'd0,
    DEC_RESTRICT = 2'd1,
    DEC_ALLOW    = 2'd2,
    DEC_RECOVERY = 2'd3
  } dec_t;

  typedef enum logic [1:0] {
    RSN_OK      = 2'd0,
    RSN_TRUST   = 2'd1,
    RSN_RING    = 2'd2,
    RSN_NOMATCH = 2'd3
  } rsn_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPERVISOR_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FABRIC_CODE = 2'd2;

  typedef struct packed {
    op_t         operation;
    logic [3:0]  slot;
    logic [31:0] handle;
    logic [15:0] action_code;
    logic [7:0]  trust_value;
    logic [15:0] ring_lower;
    logic [15:0] ring_upper;
    logic [15:0] caller_ring;
    logic        recovery_flag;
  } in_t;

  typedef struct packed {
    dec_t       decision;
    logic       matched;
    logic [3:0] matched_slot;
    rsn_t       reason;
  } out_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [15:0] action_code;
    logic [7:0]  trust_req;
    logic [15:0] ring_lower;
    logic [15:0] ring_upper;
    logic        recovery;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: src/ctc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/capability_table_check_unit.sv
// Top level of the capability table check unit: sequencer, table and decision logic.
//
// Usage: a transaction on the input channel is accepted at a rising edge where start is
// high and busy is low. A load transaction writes one table entry at in_item.slot in that
// same cycle and produces no result; slots at or above TABLE_DEPTH are ignored. An
// evaluate transaction scans entries 0 up to entries_in_use - 1 (limited to TABLE_DEPTH)
// one entry per clock through a single registered-read table RAM and one shared compare
// unit, and stops at the first entry whose handle and action code match the request.
// A match shows its result after the matching entry is read from the table RAM, compared
// and registered; with no match, after the last scanned entry is compared and the result
// registered; with a zero scan count, in the cycle after acceptance. For a nonzero scan
// count, busy is high from the cycle after acceptance until the result appears. A new
// transaction may be accepted in the cycle its predecessor's result is shown. Each
// result is shown for exactly one cycle with out_valid high; the receiver cannot stall
// it. Configuration is written on the cfg_ port when cfg_we is high; the user must write
// it only while the unit is idle, as the unit does not check it. Reset (rst_n
// low, synchronous) returns the sequencer to idle, drops out_valid and restores the
// register defaults; the table contents are undefined until loaded and need no clearing.
module capability_table_check_unit
  import ctc_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_item,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Table address width and the width of the scan counter, which must hold the count.
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = ($clog2(TABLE_DEPTH + 1) > 5) ? $clog2(TABLE_DEPTH + 1) : 5;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // Configuration registers.
  logic [4:0]  entries_in_use_r;
  logic [15:0] supervisor_code_r;
  logic [15:0] fabric_code_r;

  // Sequencer and request registers.
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic             chk_last_r, chk_last_nxt;
  logic [CNT_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [31:0]      req_handle_r;
  logic [15:0]      req_action_r;
  logic [7:0]       req_trust_r;
  logic [15:0]      req_caller_r;

  // Result registers.
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  logic             accept;
  logic [CNT_W-1:0] entries_ext;
  logic [CNT_W-1:0] scan_count;
  logic [CNT_W-1:0] slot_ext;
  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wentry;
  entry_t           ram_rentry;

  logic hit;
  logic trust_low;
  logic ring_pass;
  dec_t grant_dec;

  assign accept      = start && (state_r == ST_IDLE);
  assign busy        = (state_r != ST_IDLE);
  assign entries_ext = CNT_W'(entries_in_use_r);
  assign scan_count  = (entries_ext > DEPTH_C) ? DEPTH_C : entries_ext;
  assign slot_ext    = CNT_W'(in_item.slot);

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r  <= 5'd0;
      supervisor_code_r <= 16'd0;
      fabric_code_r     <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRIES_IN_USE:  entries_in_use_r  <= cfg_wdata[4:0];
        CFG_SUPERVISOR_CODE: supervisor_code_r <= cfg_wdata;
        CFG_FABRIC_CODE:     fabric_code_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Table storage: loads write in the accepting cycle, the scan reads one entry a cycle.
  assign ram_we = accept && (in_item.operation == OP_LOAD) && (slot_ext < DEPTH_C);
  assign ram_wentry = '{
    handle:      in_item.handle,
    action_code: in_item.action_code,
    trust_req:   in_item.trust_value,
    ring_lower:  in_item.ring_lower,
    ring_upper:  in_item.ring_upper,
    recovery:    in_item.recovery_flag
  };
  assign ram_re    = (state_r == ST_SCAN) && (ptr_r < scan_count);
  assign ram_raddr = ptr_r[IDX_W-1:0];

  ctc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_ext[IDX_W-1:0]),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rentry)
  );

  // Shared compare unit, applied to the entry read in the previous cycle.
  always_comb begin
    hit       = (ram_rentry.handle == req_handle_r) &&
                (ram_rentry.action_code == req_action_r);
    trust_low = (req_trust_r < ram_rentry.trust_req);
    if (ram_rentry.ring_lower == supervisor_code_r) begin
      ring_pass = (req_caller_r == supervisor_code_r);
    end else if (ram_rentry.ring_lower == fabric_code_r) begin
      ring_pass = (req_caller_r == supervisor_code_r) || (req_caller_r == fabric_code_r);
    end else begin
      ring_pass = (req_caller_r >= ram_rentry.ring_lower) &&
                  (req_caller_r <= ram_rentry.ring_upper);
    end
    grant_dec = ram_rentry.recovery ? DEC_RECOVERY : DEC_ALLOW;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_item.operation == OP_EVAL) && (scan_count != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chk_vld_r && (hit || chk_last_r)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Scan pointer, check pipeline and result logic.
  always_comb begin
    ptr_nxt       = ptr_r;
    chk_vld_nxt   = 1'b0;
    chk_last_nxt  = chk_last_r;
    chk_idx_nxt   = chk_idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        ptr_nxt = '0;
        if (accept && (in_item.operation == OP_EVAL) && (scan_count == '0)) begin
          // Nothing to scan: the answer is known at once.
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{decision: DEC_DENY, matched: 1'b0, matched_slot: 4'd0,
                            reason: RSN_NOMATCH};
        end
      end
      ST_SCAN: begin
        if (ram_re) begin
          ptr_nxt      = ptr_r + CNT_W'(1);
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = ptr_r;
          chk_last_nxt = ((ptr_r + CNT_W'(1)) == scan_count);
        end
        if (chk_vld_r && hit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.matched      = 1'b1;
          out_data_nxt.matched_slot = chk_idx_r[3:0];
          if (trust_low) begin
            out_data_nxt.decision = DEC_RESTRICT;
            out_data_nxt.reason   = RSN_TRUST;
          end else if (!ring_pass) begin
            out_data_nxt.decision = DEC_DENY;
            out_data_nxt.reason   = RSN_RING;
          end else begin
            out_data_nxt.decision = grant_dec;
            out_data_nxt.reason   = RSN_OK;
          end
          chk_vld_nxt = 1'b0;
        end else if (chk_vld_r && chk_last_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{decision: DEC_DENY, matched: 1'b0, matched_slot: 4'd0,
                            reason: RSN_NOMATCH};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    chk_last_r <= chk_last_nxt;
    chk_idx_r  <= chk_idx_nxt;
    out_data_r <= out_data_nxt;
    if (accept) begin
      req_handle_r <= in_item.handle;
      req_action_r <= in_item.action_code;
      req_trust_r  <= in_item.trust_value;
      req_caller_r <= in_item.caller_ring;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench of the capability table check unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctc_pkg::*;

  // The scan depth of the unit under test and the timing bounds derived from it. SCAN_SLACK
  // exceeds the busy time of a full-depth evaluate, so that much quiet after the last
  // expected result is enough for a stray or late result to show up.
  localparam int TABLE_DEPTH = 16;
  localparam int SCAN_SLACK = TABLE_DEPTH + 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PERCENT = 14;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 67;

  // The package names indexes 0 to 2 only; index 3 is an unused register index that the
  // unit must ignore.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_t                   in_item;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  capability_table_check_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Testbench copy of the unit's state: the capability table and the three registers.
  // The registers start at their reset defaults; the table is only read after the
  // stimulus has loaded every entry that a scan can reach.
  entry_t      cap_table [TABLE_DEPTH];
  logic [4:0]  scan_limit = 5'd0;
  logic [15:0] supervisor_ring = 16'd0;
  logic [15:0] fabric_ring = 16'd1;

  // Decisions predicted for accepted evaluate transactions, oldest first.
  out_t expected_decisions [$];

  // Handles and actions shared between loads and evaluates in the random traffic, so
  // that evaluates hit table entries often.
  logic [31:0] handle_pool [4];
  logic [15:0] action_pool [2];

  int          error_count = 0;
  int          decisions_checked = 0;
  int          decisions_matched = 0;
  int          loads_sent = 0;
  int          register_writes = 0;
  int unsigned cycle_count = 0;
  bit          idle_gaps = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d decisions outstanding", cycle_count,
               expected_decisions.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Ring rule of a matched entry. A window whose lower bound is the supervisor code admits
  // only the supervisor; one whose lower bound is the fabric code admits supervisor and
  // fabric. The supervisor test comes first, so it wins when the two codes are equal.
  // Any other window is an unsigned range check.
  function automatic logic ring_admits(logic [15:0] lo, logic [15:0] hi, logic [15:0] caller);
    if (lo == supervisor_ring) return caller == supervisor_ring;
    if (lo == fabric_ring) return caller == supervisor_ring || caller == fabric_ring;
    return caller >= lo && caller <= hi;
  endfunction

  // Decision for one evaluate transaction: scan in slot order, the first entry with equal
  // handle and action decides. A scan count above the table depth saturates.
  function automatic out_t predict_decision(in_t req);
    out_t        res;
    int unsigned scanned;
    logic        found;
    res.decision = DEC_DENY;
    res.matched = 1'b0;
    res.matched_slot = 4'd0;
    res.reason = RSN_NOMATCH;
    found = 1'b0;
    scanned = (scan_limit > TABLE_DEPTH) ? TABLE_DEPTH : scan_limit;
    for (int i = 0; i < scanned; i++) begin
      if (!found && cap_table[i].handle == req.handle &&
          cap_table[i].action_code == req.action_code) begin
        found = 1'b1;
        res.matched = 1'b1;
        res.matched_slot = 4'(i);
        if (req.trust_value < cap_table[i].trust_req) begin
          res.decision = DEC_RESTRICT;
          res.reason = RSN_TRUST;
        end else if (!ring_admits(cap_table[i].ring_lower, cap_table[i].ring_upper,
                                  req.caller_ring)) begin
          res.decision = DEC_DENY;
          res.reason = RSN_RING;
        end else begin
          res.decision = cap_table[i].recovery ? DEC_RECOVERY : DEC_ALLOW;
          res.reason = RSN_OK;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(string field, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // The receiver cannot stall, so every cycle with out_valid high is one result
  // transaction. Outputs are read at the edge, before the unit's own updates land.
  always @(posedge clk) begin
    out_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (expected_decisions.size() == 0) begin
        $display("%0t ns: result %h with no decision expected", $time, out_data);
        error_count++;
      end else begin
        want = expected_decisions.pop_front();
        decisions_checked++;
        if (out_data.matched === 1'b1) decisions_matched++;
        report_mismatch("decision", 4'(want.decision), 4'(out_data.decision));
        report_mismatch("matched", 4'(want.matched), 4'(out_data.matched));
        report_mismatch("matched_slot", want.matched_slot, out_data.matched_slot);
        report_mismatch("reason", 4'(want.reason), 4'(out_data.reason));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Transaction building
  // ---------------------------------------------------------------------------------------

  // Fully random transaction; also used as noise on the input while start is low, and as
  // the base of directed ones so that fields an operation ignores carry random values.
  function automatic in_t random_item();
    in_t item;
    item.operation = op_t'($urandom_range(0, 1));
    item.slot = 4'($urandom_range(0, 15));
    item.handle = $urandom;
    item.action_code = 16'($urandom);
    item.trust_value = 8'($urandom);
    item.ring_lower = 16'($urandom);
    item.ring_upper = 16'($urandom);
    item.caller_ring = 16'($urandom);
    item.recovery_flag = 1'($urandom_range(0, 1));
    return item;
  endfunction

  function automatic in_t make_load(logic [3:0] slot, logic [31:0] handle, logic [15:0] action,
                                    logic [7:0] trust, logic [15:0] lo, logic [15:0] hi,
                                    logic rec);
    in_t item;
    item = random_item();
    item.operation = OP_LOAD;
    item.slot = slot;
    item.handle = handle;
    item.action_code = action;
    item.trust_value = trust;
    item.ring_lower = lo;
    item.ring_upper = hi;
    item.recovery_flag = rec;
    return item;
  endfunction

  function automatic in_t make_eval(logic [31:0] handle, logic [15:0] action, logic [7:0] trust,
                                    logic [15:0] caller);
    in_t item;
    item = random_item();
    item.operation = OP_EVAL;
    item.handle = handle;
    item.action_code = action;
    item.trust_value = trust;
    item.caller_ring = caller;
    return item;
  endfunction

  // Trust values lean on the extremes, where the below-requirement compare is sharpest.
  function automatic logic [7:0] pick_trust();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Ring codes often equal the supervisor or fabric code so that the special ring rules
  // are reached, otherwise small or arbitrary values.
  function automatic logic [15:0] pick_ring();
    case ($urandom_range(0, 4))
      0: return supervisor_ring;
      1: return fabric_ring;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t random_load(logic [3:0] slot);
    logic [31:0] handle;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [16:0] span;
    handle = ($urandom_range(0, 7) == 0) ? $urandom : handle_pool[$urandom_range(0, 3)];
    lo = pick_ring();
    // Mostly a sensible window above the lower bound; sometimes an arbitrary upper bound,
    // which may leave the window empty.
    span = {1'b0, lo} + 17'($urandom_range(0, 'h3FFF));
    if ($urandom_range(0, 3) == 0) hi = 16'($urandom);
    else hi = span[16] ? 16'hFFFF : span[15:0];
    return make_load(slot, handle, action_pool[$urandom_range(0, 1)], pick_trust(), lo, hi,
                     1'($urandom_range(0, 1)));
  endfunction

  // Evaluates mostly ask for something a table entry holds, so that the first-match scan,
  // trust and ring rules are exercised; the rest are pool combinations or pure noise.
  function automatic in_t random_eval();
    int          pick;
    int          s;
    logic [31:0] handle;
    logic [15:0] action;
    logic [15:0] caller;
    pick = $urandom_range(0, 9);
    s = $urandom_range(0, TABLE_DEPTH - 1);
    if (pick < 6) begin
      handle = cap_table[s].handle;
      action = cap_table[s].action_code;
    end else if (pick < 9) begin
      handle = handle_pool[$urandom_range(0, 3)];
      action = action_pool[$urandom_range(0, 1)];
    end else begin
      handle = $urandom;
      action = 16'($urandom);
    end
    case ($urandom_range(0, 4))
      0: caller = supervisor_ring;
      1: caller = fabric_ring;
      2: caller = 16'($urandom);
      default: caller = 16'(cap_table[s].ring_lower + $urandom_range(0, 'h3FFF));
    endcase
    return make_eval(handle, action, pick_trust(), caller);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------------------

  // Sends one transaction. All tasks are entered just after a rising edge and leave just
  // after one, so each input gets at most one nonblocking assignment per time step. start
  // stays high between back-to-back transactions; it is only lowered by an idle gap or by
  // wait_idle, never in the step in which it is raised.
  task automatic send_item(in_t item);
    if (idle_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      in_item <= random_item();
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= item;
    // Accepted at the first edge at which busy is low.
    do @(posedge clk); while (busy !== 1'b0);
    if (item.operation == OP_LOAD) begin
      cap_table[item.slot] = '{handle: item.handle, action_code: item.action_code,
                               trust_req: item.trust_value, ring_lower: item.ring_lower,
                               ring_upper: item.ring_upper, recovery: item.recovery_flag};
      loads_sent++;
    end else begin
      expected_decisions.push_back(predict_decision(item));
    end
  endtask

  // Stops sending and waits until every predicted decision has come back, then for a full
  // scan's worth of cycles so that a trailing result or a still-busy unit cannot overlap a
  // register write that follows.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (SCAN_SLACK) @(posedge clk);
  endtask

  // One register write transaction; only called while the unit is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_ENTRIES_IN_USE: scan_limit = data[4:0];
      CFG_SUPERVISOR_CODE: supervisor_ring = data;
      CFG_FABRIC_CODE: fabric_ring = data;
      default: ;
    endcase
    register_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Right after reset the scan count is zero, so nothing can match whatever is asked.
  // No table entry is read here.
  task automatic test_empty_table();
    send_item(make_eval(32'h0000_0000, 16'h0000, 8'h00, 16'h0000));
    send_item(make_eval(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
  endtask

  // Loads the entries the directed decisions use. With the reset codes, supervisor is 0
  // and fabric is 1. Slot 15 is loaded but stays outside the scan count for now.
  task automatic test_entry_loads();
    send_item(make_load(4'd0, 32'h0000_0000, 16'h0000, 8'h00, 16'h0000, 16'hFFFF, 1'b0));
    send_item(make_load(4'd1, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'h0001, 16'h0000, 1'b1));
    send_item(make_load(4'd2, 32'h1234_5678, 16'h00A5, 8'h80, 16'd100, 16'd200, 1'b0));
    // Same handle and action as slot 2: the scan must stop at slot 2.
    send_item(make_load(4'd3, 32'h1234_5678, 16'h00A5, 8'h00, 16'h0000, 16'hFFFF, 1'b1));
    send_item(make_load(4'd4, 32'h8000_0001, 16'h8001, 8'd10, 16'hFFFF, 16'hFFFF, 1'b1));
    // Upper bound below lower bound: an empty ring window.
    send_item(make_load(4'd5, 32'h0F0F_0F0F, 16'h5A5A, 8'd1, 16'd300, 16'd299, 1'b0));
    send_item(make_load(4'd15, 32'h7FFF_FFFF, 16'h7FFF, 8'h00, 16'd2, 16'hFFFF, 1'b1));
    wait_idle();
    write_reg(CFG_ENTRIES_IN_USE, 16'd6);
  endtask

  // One evaluate per rule of the decision logic, with six entries in use.
  task automatic test_decision_rules();
    // Supervisor window: the supervisor itself is allowed, any other ring refused.
    send_item(make_eval(32'h0000_0000, 16'h0000, 8'h00, 16'h0000));
    send_item(make_eval(32'h0000_0000, 16'h0000, 8'hFF, 16'h0005));
    // Trust one below the maximum requirement gives restrict.
    send_item(make_eval(32'hFFFF_FFFF, 16'hFFFF, 8'hFE, 16'h0001));
    // Fabric window admits fabric and supervisor; the entry is recovery-only.
    send_item(make_eval(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'h0001));
    send_item(make_eval(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'h0000));
    // First match wins over the duplicate in slot 3: inside and just above the window.
    send_item(make_eval(32'h1234_5678, 16'h00A5, 8'h80, 16'd150));
    send_item(make_eval(32'h1234_5678, 16'h00A5, 8'hFF, 16'd201));
    // Window at the top of the ring code range.
    send_item(make_eval(32'h8000_0001, 16'h8001, 8'hFF, 16'hFFFF));
    // Empty window refuses even its own bound.
    send_item(make_eval(32'h0F0F_0F0F, 16'h5A5A, 8'd1, 16'd300));
    // Handle matches but action differs, and a match hidden beyond the scan count.
    send_item(make_eval(32'h1234_5678, 16'h00A6, 8'hFF, 16'd150));
    send_item(make_eval(32'h7FFF_FFFF, 16'h7FFF, 8'hFF, 16'hFFFF));
  endtask

  // Equal supervisor and fabric codes: the supervisor rule must take precedence. Also a
  // write to the unused index, which must change nothing.
  task automatic test_register_extremes();
    wait_idle();
    write_reg(CFG_SUPERVISOR_CODE, 16'd100);
    write_reg(CFG_FABRIC_CODE, 16'd100);
    write_reg(CFG_UNUSED, 16'hFFFF);
    // Slot 2 now has the supervisor code as its lower bound.
    send_item(make_eval(32'h1234_5678, 16'h00A5, 8'hFF, 16'd150));
    send_item(make_eval(32'h1234_5678, 16'h00A5, 8'hFF, 16'd100));
    wait_idle();
    write_reg(CFG_ENTRIES_IN_USE, 16'd1);
    send_item(make_eval(32'h1234_5678, 16'h00A5, 8'hFF, 16'd100));
  endtask

  // Random traffic in phases, each with its own register setting. Every slot is loaded
  // first, so from then on any scan count, saturated ones included, reads only written
  // entries.
  task automatic test_random_traffic();
    logic [4:0]  count;
    logic [15:0] sup;
    logic [15:0] fab;
    foreach (handle_pool[i]) handle_pool[i] = $urandom;
    foreach (action_pool[i]) action_pool[i] = 16'($urandom);
    for (int s = 0; s < TABLE_DEPTH; s++) send_item(random_load(4'(s)));
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin count = 5'd16; sup = 16'd0; fab = 16'd1; end
        1: begin count = 5'd0; sup = 16'hFFFF; fab = 16'h0000; end
        2: begin count = 5'd31; sup = 16'($urandom); fab = sup; end
        3: begin count = 5'd1; sup = 16'($urandom); fab = 16'($urandom); end
        4: begin count = 5'd17; sup = 16'd1; fab = 16'd0; end
        5: begin
          count = 5'($urandom_range(2, 15));
          sup = 16'($urandom_range(0, 15));
          fab = 16'($urandom_range(0, 15));
        end
        6: begin count = 5'd16; sup = 16'hFFFF; fab = 16'hFFFE; end
        default: begin count = 5'($urandom); sup = 16'($urandom); fab = 16'($urandom); end
      endcase
      wait_idle();
      // Bits above the five count bits carry noise; the count register keeps only five.
      write_reg(CFG_ENTRIES_IN_USE, {11'($urandom), count});
      write_reg(CFG_SUPERVISOR_CODE, sup);
      write_reg(CFG_FABRIC_CODE, fab);
      if (phase == RANDOM_PHASES - 1) write_reg(CFG_UNUSED, 16'($urandom));
      // One long stretch runs back to back with no idle cycles at all.
      idle_gaps = (phase != 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 9) < 3) send_item(random_load(4'($urandom_range(0, 15))));
        else send_item(random_eval());
        // Mid-phase, the sender holds off until every decision is back.
        if (phase == 5 && n == ITEMS_PER_PHASE / 2) wait_idle();
      end
    end
    idle_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_entry_loads();
    test_decision_rules();
    test_register_extremes();
    test_random_traffic();
    wait_idle();

    $display("Checked %0d decisions (%0d with a matching entry) after %0d entry loads",
             decisions_checked, decisions_matched, loads_sent);
    $display("under %0d register writes, from empty to saturated scans, in %0d cycles",
             register_writes, cycle_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
